>>> sv/trms_pkg.sv
// shared types, codes and helpers for the timed reversing motor sequencer
// no dependencies; used by trms_seq and timed_reversing_motor_sequencer_core

package trms_pkg;

    // command / state codes as they appear on the ports
    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_CW      = 3'd2;
    localparam logic [2:0] CMD_CCW     = 3'd3;
    localparam logic [2:0] CMD_RUNNING = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_CW_RUN     = 2'd0;
    localparam logic [1:0] REG_CCW_RUN    = 2'd1;
    localparam logic [1:0] REG_STOP_DWELL = 2'd2;

    localparam int CFG_BITS = 16;

    localparam logic [CFG_BITS-1:0] CW_RUN_RESET     = 16'd1000;
    localparam logic [CFG_BITS-1:0] CCW_RUN_RESET    = 16'd1000;
    localparam logic [CFG_BITS-1:0] STOP_DWELL_RESET = 16'd500;

    typedef enum logic [4:0] {
        ST_INIT    = 5'b00001,
        ST_STOP    = 5'b00010,
        ST_CW      = 5'b00100,
        ST_CCW     = 5'b01000,
        ST_RUNNING = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] cw_run_ms;
        logic [CFG_BITS-1:0] ccw_run_ms;
        logic [CFG_BITS-1:0] stop_dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic       accepted;
        logic       drive_cw;
        logic       drive_ccw;
        logic [2:0] current_state;
        logic       interlock_closed;
        logic [1:0] last_run;
    } result_t;

    function automatic state_t cmd_to_state(input logic [2:0] code);
        state_t s;
        unique case (code)
            CMD_INIT:    s = ST_INIT;
            CMD_STOP:    s = ST_STOP;
            CMD_CW:      s = ST_CW;
            CMD_CCW:     s = ST_CCW;
            CMD_RUNNING: s = ST_RUNNING;
            default:     s = ST_INIT;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] state_to_cmd(input state_t s);
        logic [2:0] code;
        unique case (s)
            ST_INIT:    code = CMD_INIT;
            ST_STOP:    code = CMD_STOP;
            ST_CW:      code = CMD_CW;
            ST_CCW:     code = CMD_CCW;
            ST_RUNNING: code = CMD_RUNNING;
            default:    code = CMD_INIT;
        endcase
        return code;
    endfunction

endpackage

>>> sv/trms_seq.sv
// sequencer state and single-step logic: one item per enabled cycle
// depends on trms_pkg

module trms_seq #(
    parameter int TIMER_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              op,
    input  logic [2:0]        command,
    input  trms_pkg::cfg_t    cfg,
    output trms_pkg::result_t res
);

    localparam int CMP_BITS = (TIMER_BITS > trms_pkg::CFG_BITS) ? TIMER_BITS
                                                                 : trms_pkg::CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    trms_pkg::state_t        state_reg, state_next;
    trms_pkg::dir_t          dir_reg, dir_next;
    trms_pkg::dir_t          prev_reg, prev_next;
    logic                    blocked_reg, blocked_next;
    logic [TIMER_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [TIMER_BITS-1:0]   elapsed_inc;
    logic [1:0]              drive_reg, drive_next;   // bit 0 cw, bit 1 ccw
    logic                    accepted;
    logic                    dwell_done, cw_done, ccw_done;

    // saturating tick count, compared after the increment
    assign elapsed_inc = (elapsed_reg == TIMER_MAX) ? elapsed_reg
                                                    : elapsed_reg + TIMER_BITS'(1);
    assign dwell_done = CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.stop_dwell_ms);
    assign cw_done    = CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.cw_run_ms);
    assign ccw_done   = CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.ccw_run_ms);

    always_comb
    begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        prev_next    = prev_reg;
        blocked_next = blocked_reg;
        elapsed_next = elapsed_reg;
        drive_next   = drive_reg;
        accepted     = 1'b0;
        if (!op)
        begin
            elapsed_next = elapsed_inc;
            unique case (state_reg) inside
                trms_pkg::ST_INIT:
                begin
                    drive_next   = 2'b00;
                    state_next   = trms_pkg::ST_STOP;
                    blocked_next = 1'b0;
                end
                trms_pkg::ST_STOP:
                begin
                    drive_next = 2'b00;
                    if (dwell_done)
                    begin
                        blocked_next = 1'b0;
                        dir_next     = trms_pkg::DIR_NONE;
                    end
                end
                trms_pkg::ST_CW, trms_pkg::ST_CCW:
                begin
                    if (dir_reg == trms_pkg::DIR_NONE)
                    begin
                        drive_next   = (state_reg == trms_pkg::ST_CW) ? 2'b01 : 2'b10;
                        dir_next     = (state_reg == trms_pkg::ST_CW) ? trms_pkg::DIR_CW
                                                                      : trms_pkg::DIR_CCW;
                        prev_next    = dir_next;
                        elapsed_next = '0;
                        state_next   = trms_pkg::ST_RUNNING;
                        blocked_next = 1'b1;
                    end
                end
                trms_pkg::ST_RUNNING:
                begin
                    if ((dir_reg == trms_pkg::DIR_CW && cw_done) ||
                        (dir_reg == trms_pkg::DIR_CCW && ccw_done))
                    begin
                        state_next   = trms_pkg::ST_STOP;
                        elapsed_next = '0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else if (!blocked_reg && command <= trms_pkg::CMD_RUNNING)
        begin
            state_next = trms_pkg::cmd_to_state(command);
            accepted   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= trms_pkg::ST_INIT;
            dir_reg     <= trms_pkg::DIR_NONE;
            prev_reg    <= trms_pkg::DIR_NONE;
            blocked_reg <= 1'b0;
            elapsed_reg <= '0;
            drive_reg   <= 2'b00;
        end
        else if (step_en)
        begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            prev_reg    <= prev_next;
            blocked_reg <= blocked_next;
            elapsed_reg <= elapsed_next;
            drive_reg   <= drive_next;
        end
    end

    always_comb
    begin
        res.accepted         = accepted;
        res.drive_cw         = drive_next[0];
        res.drive_ccw        = drive_next[1];
        res.current_state    = trms_pkg::state_to_cmd(state_next);
        res.interlock_closed = blocked_next;
        res.last_run         = prev_next;
    end

endmodule

>>> sv/timed_reversing_motor_sequencer_core.sv
// top level of the timed reversing motor sequencer: handshakes, config registers
// depends on trms_pkg and trms_seq

// Each request beat is either a one-millisecond tick (op 0) or a command
// request (op 1) and yields exactly one result beat with the drive levels,
// the command state, the interlock and the last run direction. A beat sits
// in an input register, passes the sequencer step logic and lands in a
// result register, so one beat is taken every cycle while the result
// channel is not stalled, and its result can be taken from the result
// register; the only recurrence is the sequencer state update, which
// closes within that single step. The result register holds a valid
// result while rsp_stall is high and the input register keeps taking one
// more beat behind it. Commands are taken only while the interlock is
// open; codes above four are dropped. The three run/dwell registers (cw run,
// ccw run, stop dwell, in ms) are written through the cfg port, which is
// always ready and ignores index three; write them only while idle.

module timed_reversing_motor_sequencer_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [2:0]  command,

    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        accepted,
    output logic        drive_cw,
    output logic        drive_ccw,
    output logic [2:0]  current_state,
    output logic        interlock_closed,
    output logic [1:0]  last_run,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // input stage
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [2:0]        in_command_reg;
    logic              req_take;

    // result stage
    logic              out_valid_reg;
    trms_pkg::result_t res_reg;
    trms_pkg::result_t res_next;

    // step fires when the held beat has somewhere to go
    logic              advance;

    trms_pkg::cfg_t    cfg_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // input register: payload loads on every taken beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_op_reg      <= op;
            in_command_reg <= command;
        end
    end

    // configuration registers, reset to the default run and dwell times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cw_run_ms     <= trms_pkg::CW_RUN_RESET;
            cfg_reg.ccw_run_ms    <= trms_pkg::CCW_RUN_RESET;
            cfg_reg.stop_dwell_ms <= trms_pkg::STOP_DWELL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trms_pkg::REG_CW_RUN:     cfg_reg.cw_run_ms     <= cfg_data;
                trms_pkg::REG_CCW_RUN:    cfg_reg.ccw_run_ms    <= cfg_data;
                trms_pkg::REG_STOP_DWELL: cfg_reg.stop_dwell_ms <= cfg_data;
                default:                  cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // sequencer state and step logic
    trms_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .op      (in_op_reg),
        .command (in_command_reg),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    // result register: valid drops once the beat is taken and nothing follows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign accepted         = res_reg.accepted;
    assign drive_cw         = res_reg.drive_cw;
    assign drive_ccw        = res_reg.drive_ccw;
    assign current_state    = res_reg.current_state;
    assign interlock_closed = res_reg.interlock_closed;
    assign last_run         = res_reg.last_run;

`ifndef ASSERT_OFF
    // both drive lines high would short the motor bridge
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(drive_cw && drive_ccw))
        else $error("both drive lines high");

    // a command can only be taken through an open interlock
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && accepted) |-> !interlock_closed)
        else $error("command accepted with interlock closed");

    // an active drive always matches the recorded run direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && drive_cw) |-> (last_run == trms_pkg::DIR_CW))
        else $error("cw drive without cw run recorded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && drive_ccw) |-> (last_run == trms_pkg::DIR_CCW))
        else $error("ccw drive without ccw run recorded");
`endif

endmodule
